/* design/base64url_decoder_macros.svh */
// Assertion macros for the base64url decoder.
`ifndef BASE64URL_DECODER_MACROS_SVH
`define BASE64URL_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge outside reset.
`define B64D_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("base64url_decoder: assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define B64D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("base64url_decoder: implication failed");

`else

`define B64D_ASSERT(label, clk, rst_n, cond)
`define B64D_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/b64d_pkg.sv */
// Types and constants shared by the base64url decoder modules, and the symbol decoder.
package b64d_pkg;

	// Input transaction: one raw character and its end-of-string flag
	typedef struct packed {
		logic [7:0] char_code;
		logic       string_end;
	} char_item_t;

	// Output transaction: one decoded result
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_done;
		logic       malformed;
	} res_item_t;

	// Character classes
	typedef enum logic [1:0] {
		SYM_DATA = 2'd0,
		SYM_PAD  = 2'd1,
		SYM_SKIP = 2'd2
	} sym_kind_t;

	typedef struct packed {
		sym_kind_t  kind;
		logic [5:0] value;
	} sym_t;

	// Work item handed from the front end to the output sequencer
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic            malformed;
		logic            done;
	} job_t;

	// Alphabet bounds
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_USCORE  = 8'h5F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	localparam logic [5:0] SYM_BASE_LOWER = 6'd26;
	localparam logic [5:0] SYM_BASE_DIGIT = 6'd52;
	localparam logic [5:0] SYM_VAL_DASH   = 6'd62;
	localparam logic [5:0] SYM_VAL_USCORE = 6'd63;

	// Byte slots of a job
	localparam logic [1:0] IDX_FIRST  = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_THIRD  = 2'd2;

	// Map a raw character to its six-bit value or class
	function automatic sym_t sym_decode(input logic [7:0] c);
		sym_t s;
		logic [7:0] off_upper;
		logic [7:0] off_lower;
		logic [7:0] off_digit;
		off_upper = c - CHAR_UPPER_A;
		off_lower = c - CHAR_LOWER_A;
		off_digit = c - CHAR_DIGIT_0;
		s.kind  = SYM_DATA;
		s.value = '0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			s.value = off_upper[5:0];
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			s.value = off_lower[5:0] + SYM_BASE_LOWER;
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			s.value = off_digit[5:0] + SYM_BASE_DIGIT;
		end else if (c == CHAR_DASH) begin
			s.value = SYM_VAL_DASH;
		end else if (c == CHAR_USCORE) begin
			s.value = SYM_VAL_USCORE;
		end else if (c == CHAR_PAD) begin
			s.kind = SYM_PAD;
		end else begin
			s.kind = SYM_SKIP;
		end
		return s;
	endfunction

endpackage

/* design/b64d_front.sv */
// Front end: accepts characters, updates the group state and issues jobs.
module b64d_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  b64d_pkg::char_item_t  char_item,
	input  logic                  job_ready,
	output logic                  job_push,
	output b64d_pkg::job_t        job
);

	logic [23:0]     acc_q;
	logic [1:0]      cnt_q;
	logic            pad_q;
	logic [23:0]     acc_n;
	logic [1:0]      cnt_n;
	logic            pad_n;
	logic            accept;
	logic            take_sym;
	logic            group_full;
	b64d_pkg::sym_t  sym;

	assign char_ready = job_ready;
	assign accept     = char_valid && job_ready;

	// Classify the character and shift data symbols into the accumulator
	always_comb begin
		sym      = b64d_pkg::sym_decode(char_item.char_code);
		take_sym = !pad_q && (sym.kind == b64d_pkg::SYM_DATA);
		acc_n    = take_sym ? {acc_q[17:0], sym.value} : acc_q;
		cnt_n    = take_sym ? cnt_q + 2'd1 : cnt_q;
		pad_n    = pad_q || (sym.kind == b64d_pkg::SYM_PAD);
		group_full = take_sym && (cnt_n == 2'd0);
	end

	// Build the job for this character
	always_comb begin
		job            = '0;
		job.byte_valid = 1'b1;
		job.done       = char_item.string_end;
		job_push       = accept && (char_item.string_end || group_full);
		if (group_full) begin
			job.bytes[b64d_pkg::IDX_FIRST]  = acc_n[23:16];
			job.bytes[b64d_pkg::IDX_SECOND] = acc_n[15:8];
			job.bytes[b64d_pkg::IDX_THIRD]  = acc_n[7:0];
			job.last_idx = b64d_pkg::IDX_THIRD;
		end else begin
			case (cnt_n)
				2'd2: begin
					job.bytes[b64d_pkg::IDX_FIRST] = acc_n[11:4];
					job.last_idx = b64d_pkg::IDX_FIRST;
				end
				2'd3: begin
					job.bytes[b64d_pkg::IDX_FIRST]  = acc_n[17:10];
					job.bytes[b64d_pkg::IDX_SECOND] = acc_n[9:2];
					job.last_idx = b64d_pkg::IDX_SECOND;
				end
				2'd1: begin
					job.byte_valid = 1'b0;
					job.malformed  = 1'b1;
					job.last_idx   = b64d_pkg::IDX_FIRST;
				end
				default: begin
					job.byte_valid = 1'b0;
					job.last_idx   = b64d_pkg::IDX_FIRST;
				end
			endcase
		end
	end

	// Advance the group state, clear it at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pad_q <= 1'b0;
		end else if (accept) begin
			if (char_item.string_end) begin
				acc_q <= '0;
				cnt_q <= '0;
				pad_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				cnt_q <= cnt_n;
				pad_q <= pad_n;
			end
		end
	end

endmodule

/* design/b64d_fifo.sv */
// Job queue between the front end and the output sequencer.
module b64d_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64d_pkg::job_t  push_data,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output b64d_pkg::job_t  pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::job_t    mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem[rd_ptr_q];

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* design/b64d_back.sv */
// Output sequencer: walks each job's bytes into the result register.
module b64d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  b64d_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output b64d_pkg::res_item_t  res_item
);

	logic                 res_valid_q;
	b64d_pkg::res_item_t  res_q;
	logic [1:0]           idx_q;
	logic                 load;
	logic                 take;
	logic                 at_last;

	assign load      = !res_valid_q || res_ready;
	assign take      = load && job_valid;
	assign at_last   = (idx_q == job.last_idx);
	assign job_pop   = take && at_last;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Advance the byte index and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			res_valid_q <= job_valid;
			if (take) begin
				idx_q <= at_last ? '0 : idx_q + 2'd1;
			end
		end
	end

	// Load the next result
	always_ff @(posedge clk) begin
		if (take) begin
			res_q.data_byte   <= job.bytes[idx_q];
			res_q.byte_valid  <= job.byte_valid;
			res_q.run_last    <= at_last;
			res_q.string_done <= at_last && job.done;
			res_q.malformed   <= job.malformed;
		end
	end

endmodule

/* design/base64url_decoder.sv */
// Top level of the streaming base64url decoder.
//
//   channel  direction  handshake               payload
//   char     in         char_valid/char_ready   char_item (char_code, string_end)
//   res      out        res_valid/res_ready     res_item (data_byte ... malformed)
//
// One character is taken per cycle while the job queue has room.
// Each result occupies the output register until taken: a full group gives three,
// an end of string one or two, and each passes the job queue, then the output register.
// Sustained rate is one character per cycle while res_ready is high: no stream
// averages more than one result per character; the output port moves one per cycle.
// A stalled output fills the queue of QUEUE_DEPTH jobs, then char_ready drops.
// Reset clears the group state, the queue and the output valid flag.
`include "base64url_decoder_macros.svh"

module base64url_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  b64d_pkg::char_item_t  char_item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output b64d_pkg::res_item_t   res_item
);

	logic            job_push;
	logic            job_ready;
	b64d_pkg::job_t  job_in;
	logic            job_pop;
	logic            job_valid;
	b64d_pkg::job_t  job_out;

	// Classify characters and issue jobs
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.job_ready  (job_ready),
		.job_push   (job_push),
		.job        (job_in)
	);

	// Hold pending jobs
	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (job_in),
		.push_ready (job_ready),
		.pop        (job_pop),
		.pop_valid  (job_valid),
		.pop_data   (job_out)
	);

	// Emit results
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// A string's final result is always the last of its transaction
	`B64D_ASSERT_IMPL(a_done_is_last, clk, arst_n, res_valid && res_item.string_done, res_item.run_last)

	// A malformed end carries no byte and closes the string
	`B64D_ASSERT_IMPL(a_malformed_closes, clk, arst_n, res_valid && res_item.malformed, !res_item.byte_valid && res_item.string_done)

	// Results that do not close a string carry bytes
	`B64D_ASSERT_IMPL(a_group_has_bytes, clk, arst_n, res_valid && !res_item.string_done, res_item.byte_valid)

endmodule
